FILE: src/gns_pkg.sv
package gns_pkg;

  localparam int GRID_MAX   = 64;
  localparam int FRAC_W     = 16;
  localparam int CELL_W     = $clog2(GRID_MAX);
  localparam int HALF_W     = CELL_W - 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int FX_W       = FRAC_W + 1;
  localparam int OFS_W      = FRAC_W + 2;
  localparam int GRAD_W     = 16;
  localparam int ENTRY_W    = 2 * GRAD_W;
  localparam int DOT_W      = 20;
  localparam int GS_W       = 7;
  localparam int COLOR_W    = 24;

  localparam logic [GS_W-1:0]    GRID_SIZE_RST  = GS_W'(16);
  localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 24'hFFFFFF;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_GRID_SIZE  = 1'b0;
  localparam logic REG_BASE_COLOR = 1'b1;

endpackage

FILE: src/gns_bank.sv
module gns_bank (
  input  logic                          clk,
  input  logic                          we,
  input  logic [gns_pkg::BANK_AW-1:0]   waddr,
  input  logic [gns_pkg::ENTRY_W-1:0]   wdata,
  input  logic [gns_pkg::BANK_AW-1:0]   raddr,
  output logic [gns_pkg::ENTRY_W-1:0]   rdata
);

  logic [gns_pkg::ENTRY_W-1:0] mem [2**gns_pkg::BANK_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gradient_noise_sampler.sv
// 2-D gradient noise sampler. One item is taken per clock (busy stays low):
// a load item writes one gradient into the lattice table, a sample item gives
// one result on the out_ ports for exactly one cycle with out_valid high,
// from the last of nine register stages, the output register. Results
// cannot be held off; take them when seen. The lattice table sits in four
// banks split by row and column parity, so the four corners of any cell
// are read in the same cycle. Loads write the table in the same stage where
// samples read it, so items act in the order taken. Every table entry must
// be loaded before a sample reads it. The user must write configuration
// (grid_size, base_color) only while no sample is in flight (unenforced).
module gradient_noise_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [5:0]                        in_cell_x,
  input  logic [5:0]                        in_cell_y,
  input  logic signed [15:0]                in_grad_x,
  input  logic signed [15:0]                in_grad_y,
  input  logic [15:0]                       in_coord_u,
  input  logic [15:0]                       in_coord_v,
  output logic                              out_valid,
  output logic [15:0]                       out_noise_level,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [23:0]                       cfg_wdata
);

  localparam int FW  = gns_pkg::FRAC_W;
  localparam int FXW = gns_pkg::FX_W;
  localparam int OW  = gns_pkg::OFS_W;
  localparam int CW  = gns_pkg::CELL_W;
  localparam int HW  = gns_pkg::HALF_W;
  localparam int DW  = gns_pkg::DOT_W;
  localparam int PW  = FW + CW;
  localparam logic [FXW-1:0] ONE = FXW'(1) << FW;

  // pipeline never stalls
  assign busy = 1'b0;

  // configuration
  logic [gns_pkg::GS_W-1:0]    grid_size_r;
  logic [gns_pkg::COLOR_W-1:0] base_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= gns_pkg::GRID_SIZE_RST;
      base_color_r <= gns_pkg::BASE_COLOR_RST;
    end else if (cfg_we) begin
      if (cfg_index == gns_pkg::REG_GRID_SIZE) begin
        grid_size_r <= cfg_wdata[gns_pkg::GS_W-1:0];
      end else begin
        base_color_r <= cfg_wdata[gns_pkg::COLOR_W-1:0];
      end
    end
  end

  // grid size clamped to [2, GRID_MAX]
  logic [gns_pkg::GS_W-1:0] gs;
  logic [CW-1:0]            gsm1, gsm2;
  always_comb begin
    if (grid_size_r < gns_pkg::GS_W'(2)) begin
      gs = gns_pkg::GS_W'(2);
    end else if (grid_size_r > gns_pkg::GS_W'(gns_pkg::GRID_MAX)) begin
      gs = gns_pkg::GS_W'(gns_pkg::GRID_MAX);
    end else begin
      gs = grid_size_r;
    end
    gsm1 = CW'(gs - gns_pkg::GS_W'(1));
    gsm2 = CW'(gs - gns_pkg::GS_W'(2));
  end

  // ---- stage 1: lattice position -------------------------------------
  logic [PW-1:0] pu, pv;
  logic [CW-1:0] x0_nxt, y0_nxt;
  logic [FXW-1:0] fx_nxt, fy_nxt;
  always_comb begin
    pu = PW'(in_coord_u) * PW'(gsm1);
    pv = PW'(in_coord_v) * PW'(gsm1);
    // upper corner past the grid: clamp cell, fraction becomes 1.0
    if (pu[PW-1:FW] > gsm2) begin
      x0_nxt = gsm2;
      fx_nxt = ONE;
    end else begin
      x0_nxt = pu[PW-1:FW];
      fx_nxt = {1'b0, pu[FW-1:0]};
    end
    if (pv[PW-1:FW] > gsm2) begin
      y0_nxt = gsm2;
      fy_nxt = ONE;
    end else begin
      y0_nxt = pv[PW-1:FW];
      fy_nxt = {1'b0, pv[FW-1:0]};
    end
  end

  logic                          v1_r, cmd1_r;
  logic [CW-1:0]                 lx1_r, ly1_r;
  logic [gns_pkg::ENTRY_W-1:0]   lg1_r;
  logic [CW-1:0]                 x01_r, y01_r;
  logic [FXW-1:0]                fx1_r, fy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_cmd;
    lx1_r  <= in_cell_x;
    ly1_r  <= in_cell_y;
    lg1_r  <= {in_grad_y, in_grad_x};
    x01_r  <= x0_nxt;
    y01_r  <= y0_nxt;
    fx1_r  <= fx_nxt;
    fy1_r  <= fy_nxt;
  end

  // ---- stage 2: table access, squared fractions ----------------------
  // bank b = {y parity, x parity}; address = {y >> 1, x >> 1}
  logic [CW-1:0] xe, xo, ye, yo;
  always_comb begin
    xe = x01_r[0] ? x01_r + CW'(1) : x01_r;
    xo = x01_r[0] ? x01_r : x01_r + CW'(1);
    ye = y01_r[0] ? y01_r + CW'(1) : y01_r;
    yo = y01_r[0] ? y01_r : y01_r + CW'(1);
  end

  logic [gns_pkg::ENTRY_W-1:0] rd [4];
  logic [HW-1:0]               bx [2];
  logic [HW-1:0]               by [2];
  assign bx[0] = xe[CW-1:1];
  assign bx[1] = xo[CW-1:1];
  assign by[0] = ye[CW-1:1];
  assign by[1] = yo[CW-1:1];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    gns_bank u_bank (
      .clk  (clk),
      .we   (v1_r && cmd1_r == gns_pkg::CMD_LOAD && {ly1_r[0], lx1_r[0]} == 2'(b)),
      .waddr({ly1_r[CW-1:1], lx1_r[CW-1:1]}),
      .wdata(lg1_r),
      .raddr({by[b/2], bx[b%2]}),
      .rdata(rd[b])
    );
  end

  logic [2*FXW-1:0] sqx, sqy;
  assign sqx = (2*FXW)'(fx1_r) * (2*FXW)'(fx1_r);
  assign sqy = (2*FXW)'(fy1_r) * (2*FXW)'(fy1_r);

  logic           v2_r;
  logic [FXW-1:0] fx2_r, fy2_r, f2x2_r, f2y2_r;
  logic           px2_r, py2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r && cmd1_r == gns_pkg::CMD_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    fx2_r  <= fx1_r;
    fy2_r  <= fy1_r;
    f2x2_r <= sqx[FW+FXW-1:FW];
    f2y2_r <= sqy[FW+FXW-1:FW];
    px2_r  <= x01_r[0];
    py2_r  <= y01_r[0];
  end

  // ---- stage 3: corner products and smoothstep weights ---------------
  // corner k = {dy, dx}; offsets f or f - 1.0
  localparam int MW = OW + gns_pkg::GRAD_W;
  logic signed [OW-1:0] ox [2];
  logic signed [OW-1:0] oy [2];
  assign ox[0] = $signed(OW'(fx2_r));
  assign ox[1] = $signed(OW'(fx2_r) - OW'(ONE));
  assign oy[0] = $signed(OW'(fy2_r));
  assign oy[1] = $signed(OW'(fy2_r) - OW'(ONE));

  logic signed [MW-1:0] px_nxt [4];
  logic signed [MW-1:0] py_nxt [4];
  logic [gns_pkg::ENTRY_W-1:0] ent [4];
  for (genvar k = 0; k < 4; k++) begin : g_corner
    assign ent[k] = rd[{py2_r ^ 1'(k/2), px2_r ^ 1'(k%2)}];
    assign px_nxt[k] = MW'(ox[k%2]) * MW'($signed(ent[k][gns_pkg::GRAD_W-1:0]));
    assign py_nxt[k] = MW'(oy[k/2]) * MW'($signed(ent[k][gns_pkg::ENTRY_W-1:gns_pkg::GRAD_W]));
  end

  localparam int TW = FXW + 1;
  localparam int WW = FXW + TW;
  logic [TW-1:0] tx, ty;
  logic [WW-1:0] wpx, wpy;
  assign tx  = TW'(3) * TW'(ONE) - (TW'(fx2_r) << 1);
  assign ty  = TW'(3) * TW'(ONE) - (TW'(fy2_r) << 1);
  assign wpx = WW'(f2x2_r) * WW'(tx);
  assign wpy = WW'(f2y2_r) * WW'(ty);

  logic                 v3_r;
  logic signed [MW-1:0] px3_r [4];
  logic signed [MW-1:0] py3_r [4];
  logic [FXW-1:0]       wx3_r, wy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    px3_r <= px_nxt;
    py3_r <= py_nxt;
    wx3_r <= wpx[FW+FXW-1:FW];
    wy3_r <= wpy[FW+FXW-1:FW];
  end

  // ---- stage 4: dot products to Q.16 (floor) -------------------------
  logic signed [MW:0] dsum [4];
  logic               v4_r;
  logic signed [DW-1:0] d4_r [4];
  logic [FXW-1:0]     wx4_r, wy4_r;

  for (genvar k = 0; k < 4; k++) begin : g_dot
    assign dsum[k] = (MW+1)'(px3_r[k]) + (MW+1)'(py3_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      d4_r[k] <= $signed(dsum[k][FW-2+DW-1:FW-2]);
    end
    wx4_r <= wx3_r;
    wy4_r <= wy3_r;
  end

  // ---- stage 5: x blend products -------------------------------------
  localparam int BW = DW + 1;
  localparam int LW = BW + FXW + 1;
  logic signed [BW-1:0] dfx0, dfx1;
  logic signed [LW-1:0] mx0_nxt, mx1_nxt;
  assign dfx0    = BW'(d4_r[1]) - BW'(d4_r[0]);
  assign dfx1    = BW'(d4_r[3]) - BW'(d4_r[2]);
  assign mx0_nxt = LW'($signed({1'b0, wx4_r})) * LW'(dfx0);
  assign mx1_nxt = LW'($signed({1'b0, wx4_r})) * LW'(dfx1);

  logic                 v5_r;
  logic signed [LW-1:0] mx05_r, mx15_r;
  logic signed [DW-1:0] a05_r, a15_r;
  logic [FXW-1:0]       wy5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    mx05_r <= mx0_nxt;
    mx15_r <= mx1_nxt;
    a05_r  <= d4_r[0];
    a15_r  <= d4_r[2];
    wy5_r  <= wy4_r;
  end

  // ---- stage 6: x blend sums ------------------------------------------
  logic signed [LW-1:0] sh0, sh1;
  assign sh0 = mx05_r >>> FW;
  assign sh1 = mx15_r >>> FW;

  logic                 v6_r;
  logic signed [DW-1:0] l06_r, l16_r;
  logic [FXW-1:0]       wy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    l06_r <= a05_r + DW'(sh0);
    l16_r <= a15_r + DW'(sh1);
    wy6_r <= wy5_r;
  end

  // ---- stage 7: y blend product ---------------------------------------
  logic signed [BW-1:0] dfy;
  assign dfy = BW'(l16_r) - BW'(l06_r);

  logic                 v7_r;
  logic signed [LW-1:0] my7_r;
  logic signed [DW-1:0] l07_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    my7_r <= LW'($signed({1'b0, wy6_r})) * LW'(dfy);
    l07_r <= l06_r;
  end

  // ---- stage 8: noise to level, saturated ----------------------------
  logic signed [LW-1:0] shy;
  logic signed [DW-1:0] n8;
  logic signed [DW:0]   lv;
  logic [15:0]          lvl_nxt;
  always_comb begin
    shy = my7_r >>> FW;
    n8  = l07_r + DW'(shy);
    lv  = (DW+1)'(n8 >>> 1) + (DW+1)'(32768);
    if (lv < 0) begin
      lvl_nxt = 16'd0;
    end else if (lv > (DW+1)'(65535)) begin
      lvl_nxt = 16'hFFFF;
    end else begin
      lvl_nxt = lv[15:0];
    end
  end

  logic        v8_r;
  logic [15:0] lvl8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl8_r <= lvl_nxt;
  end

  // ---- stage 9: color scale, output register -------------------------
  logic [23:0] pr, pg, pb;
  assign pr = 24'(base_color_r[23:16]) * 24'(lvl8_r);
  assign pg = 24'(base_color_r[15:8])  * 24'(lvl8_r);
  assign pb = 24'(base_color_r[7:0])   * 24'(lvl8_r);

  logic        v9_r;
  logic [15:0] lvl9_r;
  logic [7:0]  red9_r, green9_r, blue9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl9_r   <= lvl8_r;
    red9_r   <= pr[23:16];
    green9_r <= pg[23:16];
    blue9_r  <= pb[23:16];
  end

  assign out_valid       = v9_r;
  assign out_noise_level = lvl9_r;
  assign out_red         = red9_r;
  assign out_green       = green9_r;
  assign out_blue        = blue9_r;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for gradient_noise_sampler.
// Loads fill the lattice on demand so that no sample ever reads an unloaded
// entry. Each sample's color is predicted here and queued. A monitor compares
// each strobed result with the oldest queued prediction.
module testbench;

  typedef struct packed {
    logic [15:0] level;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } texel_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 12;   // pipeline depth plus margin
  localparam int ITEM_TARGET    = 1850;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_cmd;
  logic [5:0]        in_cell_x;
  logic [5:0]        in_cell_y;
  logic signed [15:0] in_grad_x;
  logic signed [15:0] in_grad_y;
  logic [15:0]       in_coord_u;
  logic [15:0]       in_coord_v;
  logic              out_valid;
  logic [15:0]       out_noise_level;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              cfg_we;
  logic              cfg_index;
  logic [23:0]       cfg_wdata;

  gradient_noise_sampler uut (.*);

  // Bench copy of block state.
  logic [31:0]                 grad_table [gns_pkg::GRID_MAX*gns_pkg::GRID_MAX];
  bit                          loaded     [gns_pkg::GRID_MAX*gns_pkg::GRID_MAX];
  logic [gns_pkg::GS_W-1:0]    grid_size_q;
  logic [gns_pkg::COLOR_W-1:0] base_color_q;

  texel_t texel_q [$];
  int     fail_count;
  int     item_count;
  int     sample_count;
  int     load_count;
  int     cfg_count;
  int     idle_cycles;
  bit     burst_mode;   // no gaps while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic longint eff_grid();
    longint g;
    g = grid_size_q;
    if (g < 2) g = 2;
    if (g > gns_pkg::GRID_MAX) g = gns_pkg::GRID_MAX;
    return g;
  endfunction

  // Lattice cell and Q1.16 fraction; upper cells clamp with fraction 1.0.
  task automatic find_cell(input logic [15:0] coord, output longint cell_idx,
                           output longint frac);
    longint g, p, c;
    g = eff_grid();
    p = longint'(coord) * (g - 1);
    c = p >> gns_pkg::FRAC_W;
    if (c > g - 2) begin
      cell_idx = g - 2;
      frac = longint'(1) << gns_pkg::FRAC_W;
    end else begin
      cell_idx = c;
      frac = p - (c << gns_pkg::FRAC_W);
    end
  endtask

  function automatic longint smooth_weight(longint f);
    longint f2;
    f2 = (f * f) >> gns_pkg::FRAC_W;
    return (f2 * (3 * (longint'(1) << gns_pkg::FRAC_W) - 2 * f)) >> gns_pkg::FRAC_W;
  endfunction

  function automatic longint corner_dot(longint cx, longint cy, longint ox,
                                        longint oy);
    logic [31:0] e;
    longint gx, gy;
    e  = grad_table[(cy * gns_pkg::GRID_MAX + cx) %
                    (gns_pkg::GRID_MAX * gns_pkg::GRID_MAX)];
    gx = longint'($signed(e[15:0]));
    gy = longint'($signed(e[31:16]));
    return (ox * gx + oy * gy) >>> (gns_pkg::FRAC_W - 2);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + ((w * (b - a)) >>> gns_pkg::FRAC_W);
  endfunction

  task automatic shade_sample(input logic [15:0] u, input logic [15:0] v,
                              output texel_t t);
    longint one, x0, y0, fx, fy, wx, wy, d00, d10, d01, d11, n, lvl;
    one = longint'(1) << gns_pkg::FRAC_W;
    find_cell(u, x0, fx);
    find_cell(v, y0, fy);
    wx  = smooth_weight(fx);
    wy  = smooth_weight(fy);
    d00 = corner_dot(x0, y0, fx, fy);
    d10 = corner_dot(x0 + 1, y0, fx - one, fy);
    d01 = corner_dot(x0, y0 + 1, fx, fy - one);
    d11 = corner_dot(x0 + 1, y0 + 1, fx - one, fy - one);
    n   = mix(mix(d00, d10, wx), mix(d01, d11, wx), wy);
    lvl = (n >>> 1) + 32768;
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    t.level = lvl[15:0];
    t.red   = 8'((longint'(base_color_q[23:16]) * lvl) >> 16);
    t.green = 8'((longint'(base_color_q[15:8]) * lvl) >> 16);
    t.blue  = 8'((longint'(base_color_q[7:0]) * lvl) >> 16);
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // One item: presented at the falling edge, held until accepted.
  task automatic send_item(input logic cmd, input logic [5:0] cx,
                           input logic [5:0] cy, input logic [15:0] gx,
                           input logic [15:0] gy, input logic [15:0] u,
                           input logic [15:0] v);
    texel_t t;
    int gap;
    @(negedge clk);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_cell_x  <= cx;
    in_cell_y  <= cy;
    in_grad_x  <= gx;
    in_grad_y  <= gy;
    in_coord_u <= u;
    in_coord_v <= v;
    do @(posedge clk); while (busy);
    item_count++;
    if (cmd == gns_pkg::CMD_LOAD) begin
      grad_table[{cy, cx}] = {gy, gx};
      loaded[{cy, cx}]     = 1'b1;
      load_count++;
    end else begin
      shade_sample(u, v, t);
      texel_q.push_back(t);
      sample_count++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] rand_grad();
    return 16'($urandom_range(32768) - 16384);
  endfunction

  task automatic load_cell(input int cx, input int cy);
    send_item(gns_pkg::CMD_LOAD, 6'(cx), 6'(cy), rand_grad(), rand_grad(),
              16'($urandom), 16'($urandom));
  endtask

  // Sample, first loading any corner that was never written.
  task automatic sample_at(input logic [15:0] u, input logic [15:0] v);
    longint x0, y0, fx, fy;
    find_cell(u, x0, fx);
    find_cell(v, y0, fy);
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++)
        if (!loaded[(y0 + dy) * gns_pkg::GRID_MAX + x0 + dx])
          load_cell(int'(x0) + dx, int'(y0) + dy);
    send_item(gns_pkg::CMD_SAMPLE, 6'($urandom), 6'($urandom), 16'($urandom),
              16'($urandom), u, v);
  endtask

  // Idle: inputs quiet, all predictions seen, pipeline given time to empty.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [23:0] data);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == gns_pkg::REG_GRID_SIZE) grid_size_q = data[gns_pkg::GS_W-1:0];
    else base_color_q = data;
    cfg_count++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    texel_t e;
    if (rst_n && out_valid) begin
      if (texel_q.size() == 0) begin
        $error("unexpected result: level %0d", out_noise_level);
        fail_count++;
      end else begin
        e = texel_q.pop_front();
        if (out_noise_level !== e.level) begin
          $error("noise_level expected %0d actual %0d", e.level, out_noise_level);
          fail_count++;
        end
        if (out_red !== e.red) begin
          $error("red expected %0d actual %0d", e.red, out_red);
          fail_count++;
        end
        if (out_green !== e.green) begin
          $error("green expected %0d actual %0d", e.green, out_green);
          fail_count++;
        end
        if (out_blue !== e.blue) begin
          $error("blue expected %0d actual %0d", e.blue, out_blue);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no item taken and no result seen.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset config (grid 16, white), coordinate extremes, gradient extremes.
  task automatic test_reset_defaults();
    send_item(gns_pkg::CMD_LOAD, 6'd0, 6'd0, 16'sh4000, 16'sh4000, 16'h0, 16'h0);
    send_item(gns_pkg::CMD_LOAD, 6'd1, 6'd0, -16'sd16384, 16'sh4000, 16'hFFFF,
              16'h0);
    send_item(gns_pkg::CMD_LOAD, 6'd0, 6'd1, 16'sh4000, -16'sd16384, 16'h0,
              16'hFFFF);
    send_item(gns_pkg::CMD_LOAD, 6'd1, 6'd1, -16'sd16384, -16'sd16384, 16'hFFFF,
              16'hFFFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'h0800, 16'h0800);   // mid cell, strong gradients
    sample_at(16'h1000, 16'h0400);
    sample_at(16'hFFFF, 16'hFFFF);   // last cell, fraction just below 1.0
    sample_at(16'hFFFF, 16'h0000);
  endtask

  // Grid size at both ends and outside its range (clamps to 2 and 64).
  task automatic test_grid_extremes();
    logic [23:0] sizes [5] = '{24'd2, 24'd64, 24'd0, 24'd1, 24'd127};
    foreach (sizes[i]) begin
      write_cfg(gns_pkg::REG_GRID_SIZE, sizes[i]);
      sample_at(16'h0000, 16'hFFFF);
      sample_at(16'hFFFF, 16'h8000);
    end
  endtask

  // Base color: black, one channel at a time.
  task automatic test_color_channels();
    write_cfg(gns_pkg::REG_GRID_SIZE, 24'd4);
    write_cfg(gns_pkg::REG_BASE_COLOR, 24'h000000);
    sample_at(16'h6000, 16'h3000);
    write_cfg(gns_pkg::REG_BASE_COLOR, 24'hFF0000);
    sample_at(16'h6000, 16'h3000);
    write_cfg(gns_pkg::REG_BASE_COLOR, 24'h00FF00);
    sample_at(16'h2000, 16'hA000);
    write_cfg(gns_pkg::REG_BASE_COLOR, 24'h0000FF);
    sample_at(16'hC000, 16'h5000);
  endtask

  // Random phases: mostly samples, some overwriting loads, varied settings.
  task automatic test_random_mix();
    int phase;
    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (phase % 3 == 2) write_cfg(gns_pkg::REG_GRID_SIZE, 24'($urandom_range(127)));
      else write_cfg(gns_pkg::REG_GRID_SIZE, 24'($urandom_range(12, 2)));
      write_cfg(gns_pkg::REG_BASE_COLOR, 24'($urandom));
      burst_mode = (phase % 4 == 1);
      for (int i = 0; i < 120 && item_count < ITEM_TARGET; i++) begin
        if ($urandom_range(99) < 20)
          load_cell($urandom_range(gns_pkg::GRID_MAX - 1),
                    $urandom_range(gns_pkg::GRID_MAX - 1));
        else
          sample_at(16'($urandom), 16'($urandom));
      end
      phase++;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = gns_pkg::CMD_LOAD;
    in_cell_x    = '0;
    in_cell_y    = '0;
    in_grad_x    = '0;
    in_grad_y    = '0;
    in_coord_u   = '0;
    in_coord_v   = '0;
    cfg_we       = 1'b0;
    cfg_index    = gns_pkg::REG_GRID_SIZE;
    cfg_wdata    = '0;
    fail_count   = 0;
    item_count   = 0;
    sample_count = 0;
    load_count   = 0;
    cfg_count    = 0;
    burst_mode   = 1'b0;
    grid_size_q  = gns_pkg::GRID_SIZE_RST;
    base_color_q = gns_pkg::BASE_COLOR_RST;
    foreach (loaded[i]) begin
      loaded[i]     = 1'b0;
      grad_table[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_grid_extremes();
    test_color_channels();
    test_random_mix();
    drain();

    $display("covered %0d items: %0d samples, %0d gradient loads", item_count,
             sample_count, load_count);
    $display("%0d register writes over grid sizes 0..127 and random colors",
             cfg_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: gradient_noise_sampler.f
src/gns_pkg.sv
src/gns_bank.sv
src/gradient_noise_sampler.sv
dv/testbench.sv
